// File: hw/rtl/lsmp_pkg.sv
// Shared types and constants for the Lucas sequence modular power core.
`default_nettype none
package lsmp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_SETUP,
    ST_BIT,
    ST_OPERAND,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_STEP,
    OP_SETUP,
    OP_MUL_START,
    OP_MUL_STEP,
    OP_MUL_WB,
    OP_FINAL
  } op_t;

  // product select: multiply pairs, square pairs, then the two final products
  typedef logic [4:0] sel_t;

  typedef struct packed {
    op_t  op;
    sel_t prod_sel;
  } cmd_t;

  typedef struct packed {
    logic red_last;
    logic mul_done;
    logic exp_zero;
    logic exp_bit;
    logic skip_pow;
  } status_t;

  localparam sel_t SEL_MUL_FIRST = 5'd0;
  localparam sel_t SEL_MUL_LAST  = 5'd7;
  localparam sel_t SEL_SQR_FIRST = 5'd8;
  localparam sel_t SEL_SQR_LAST  = 5'd15;
  localparam sel_t SEL_FIN_FIRST = 5'd16;
  localparam sel_t SEL_FIN_LAST  = 5'd17;

  // configuration register indexes
  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_EVEN    = 1'b1;

  localparam logic [63:0] MODULUS_RESET = 64'd7528443412579576937;

endpackage
`default_nettype wire

// File: hw/rtl/lucas_sequence_mod_power_core.sv
// Top level of the Lucas sequence modular power core, with its controller.
`default_nettype none
// Each word on start (taken when busy is low) gives b, d and n; the core returns term n of
// V_k = b*V_(k-1) + c*V_(k-2), V_0 = 2, V_1 = b, modulo the configured modulus, one result
// per word, shown for one cycle with out_valid. The receiver cannot stall: sample the result
// in that cycle. Items run one at a time. Each item steps through load, reduction and setup,
// then per exponent bit of n-1 one decision step plus 16 products for a set bit or 8 for a
// clear one, one final decision and 2 products, then finish and result. A product steps
// through the bits of its second operand (at most 63 of them); index zero or modulus zero
// skip the products. Busy drops the cycle after the result. Configuration is taken only
// while idle with start low.
module lucas_sequence_mod_power_core #(
  parameter int unsigned INDEX_BITS = 62,
  parameter int unsigned VALUE_BITS = 63
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire [30:0]            in_base_term,
  input  wire [61:0]            in_discriminant,
  input  wire [INDEX_BITS-1:0]  in_term_index,
  output logic                  out_valid,
  output logic [VALUE_BITS-1:0] out_term_value,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_index,
  input  wire [VALUE_BITS-1:0]  cfg_data
);

  logic [VALUE_BITS-1:0] modulus_r;
  logic                  even_r;
  lsmp_pkg::cmd_t        cmd;
  lsmp_pkg::status_t     status;

  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= VALUE_BITS'(lsmp_pkg::MODULUS_RESET);
      even_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsmp_pkg::CFG_MODULUS: modulus_r <= cfg_data;
        lsmp_pkg::CFG_EVEN:    even_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lsmp_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  lsmp_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .modulus        (modulus_r),
    .even_minus_one (even_r),
    .base_term      (in_base_term),
    .discriminant   (in_discriminant),
    .term_index     (in_term_index),
    .result         (out_term_value)
  );

`ifndef SYNTHESIS
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy);
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid);
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready |-> !busy);
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid);
  a_value_known: assert property (@(posedge clk) disable iff (!rst_n)
                                  out_valid |-> !$isunknown(out_term_value));
`endif

endmodule

module lsmp_controller (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  lsmp_pkg::status_t status,
  output lsmp_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              out_valid
);

  lsmp_pkg::state_t state_r, state_nxt;
  lsmp_pkg::sel_t   sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsmp_pkg::ST_IDLE;
      sel_r   <= lsmp_pkg::SEL_MUL_FIRST;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sel_nxt      = sel_r;
    cmd.op       = lsmp_pkg::OP_NONE;
    cmd.prod_sel = sel_r;
    busy         = 1'b1;
    out_valid    = 1'b0;
    case (state_r)
      lsmp_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op    = lsmp_pkg::OP_LOAD;
          state_nxt = lsmp_pkg::ST_RED;
        end
      end
      lsmp_pkg::ST_RED: begin
        cmd.op = lsmp_pkg::OP_RED_STEP;
        if (status.red_last) state_nxt = lsmp_pkg::ST_SETUP;
      end
      lsmp_pkg::ST_SETUP: begin
        cmd.op    = lsmp_pkg::OP_SETUP;
        state_nxt = status.skip_pow ? lsmp_pkg::ST_FIN : lsmp_pkg::ST_BIT;
      end
      lsmp_pkg::ST_BIT: begin
        // multiply on a set bit, square always, finish once the exponent runs out
        if (status.exp_zero) sel_nxt = lsmp_pkg::SEL_FIN_FIRST;
        else if (status.exp_bit) sel_nxt = lsmp_pkg::SEL_MUL_FIRST;
        else sel_nxt = lsmp_pkg::SEL_SQR_FIRST;
        state_nxt = lsmp_pkg::ST_OPERAND;
      end
      lsmp_pkg::ST_OPERAND: begin
        cmd.op    = lsmp_pkg::OP_MUL_START;
        state_nxt = lsmp_pkg::ST_MUL;
      end
      lsmp_pkg::ST_MUL: begin
        if (!status.mul_done) begin
          cmd.op = lsmp_pkg::OP_MUL_STEP;
        end else begin
          cmd.op = lsmp_pkg::OP_MUL_WB;
          if (sel_r == lsmp_pkg::SEL_FIN_LAST) begin
            state_nxt = lsmp_pkg::ST_FIN;
          end else if (sel_r == lsmp_pkg::SEL_SQR_LAST) begin
            state_nxt = lsmp_pkg::ST_BIT;
          end else begin
            sel_nxt   = sel_r + 5'd1;
            state_nxt = lsmp_pkg::ST_OPERAND;
          end
        end
      end
      lsmp_pkg::ST_FIN: begin
        cmd.op    = lsmp_pkg::OP_FINAL;
        state_nxt = lsmp_pkg::ST_OUT;
      end
      lsmp_pkg::ST_OUT: begin
        out_valid = 1'b1;
        state_nxt = lsmp_pkg::ST_IDLE;
      end
      default: state_nxt = lsmp_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/lsmp_datapath.sv
// Datapath: coefficient and base reduction, shared double-and-add multiplier and matrix registers.
`default_nettype none
module lsmp_datapath #(
  parameter int unsigned INDEX_BITS = 62,
  parameter int unsigned VALUE_BITS = 63
) (
  input  wire                         clk,
  input  lsmp_pkg::cmd_t              cmd,
  output lsmp_pkg::status_t           status,
  input  wire [VALUE_BITS-1:0]        modulus,
  input  wire                         even_minus_one,
  input  wire [30:0]                  base_term,
  input  wire [61:0]                  discriminant,
  input  wire [INDEX_BITS-1:0]        term_index,
  output logic [VALUE_BITS-1:0]       result
);

  localparam int unsigned RW = 64; // width of reduction numerators
  localparam int unsigned CW = 6;

  logic [VALUE_BITS-1:0] m_r;
  logic [INDEX_BITS-1:0] e_r, n_r;
  logic                  neg_r, em1_r;
  logic [RW-1:0]         numc_r, numb_r; // numerators being reduced, msb first
  logic [VALUE_BITS-1:0] remc_r, remb_r;
  logic [CW-1:0]         rcnt_r;
  logic [VALUE_BITS-1:0] b00_r, b01_r, b10_r, b11_r;
  logic [VALUE_BITS-1:0] r00_r, r01_r, r10_r, r11_r;
  logic [VALUE_BITS-1:0] t_r [4];
  logic [VALUE_BITS-1:0] ma_r, mb_r, acc_r;
  logic [VALUE_BITS-1:0] result_r;

  // modular add, both operands below m
  function automatic logic [VALUE_BITS-1:0] madd(input logic [VALUE_BITS-1:0] a,
                                                 input logic [VALUE_BITS-1:0] b,
                                                 input logic [VALUE_BITS-1:0] m);
    logic [VALUE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[VALUE_BITS-1:0];
  endfunction

  // one restoring reduction step: shift in a numerator bit, subtract m once
  function automatic logic [VALUE_BITS-1:0] rstep(input logic [VALUE_BITS-1:0] rem,
                                                  input logic                  nbit,
                                                  input logic [VALUE_BITS-1:0] m);
    logic [VALUE_BITS:0] sh;
    sh = {rem, nbit};
    if (sh >= {1'b0, m}) sh = sh - {1'b0, m};
    return sh[VALUE_BITS-1:0];
  endfunction

  logic [63:0] d_w, b2_w, num_w;
  logic        neg_w;
  logic [VALUE_BITS-1:0] one_w, two_w, c_w;
  logic [VALUE_BITS-1:0] pa_w, pb_w, sum_w, fin_w;
  logic [1:0]            tk_w;

  assign d_w   = {2'b00, discriminant};
  assign b2_w  = {33'd0, base_term} * {33'd0, base_term};
  assign neg_w = d_w < b2_w;
  // floor towards minus infinity: negate the rounded-up magnitude later
  assign num_w = neg_w ? ((b2_w - d_w + 64'd3) >> 2) : ((d_w - b2_w) >> 2);

  assign one_w = (m_r == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);
  assign two_w = (m_r > VALUE_BITS'(2)) ? VALUE_BITS'(2) : '0;
  assign c_w   = (!neg_r || remc_r == '0) ? remc_r : m_r - remc_r;

  // operand pairs: 0..7 base*r, 8..15 base*base, 16..17 final term
  always_comb begin
    pa_w = b00_r;
    pb_w = r00_r;
    case (cmd.prod_sel)
      5'd0:  begin pa_w = b00_r; pb_w = r00_r; end
      5'd1:  begin pa_w = b01_r; pb_w = r10_r; end
      5'd2:  begin pa_w = b00_r; pb_w = r01_r; end
      5'd3:  begin pa_w = b01_r; pb_w = r11_r; end
      5'd4:  begin pa_w = b10_r; pb_w = r00_r; end
      5'd5:  begin pa_w = b11_r; pb_w = r10_r; end
      5'd6:  begin pa_w = b10_r; pb_w = r01_r; end
      5'd7:  begin pa_w = b11_r; pb_w = r11_r; end
      5'd8:  begin pa_w = b00_r; pb_w = b00_r; end
      5'd9:  begin pa_w = b01_r; pb_w = b10_r; end
      5'd10: begin pa_w = b00_r; pb_w = b01_r; end
      5'd11: begin pa_w = b01_r; pb_w = b11_r; end
      5'd12: begin pa_w = b10_r; pb_w = b00_r; end
      5'd13: begin pa_w = b11_r; pb_w = b10_r; end
      5'd14: begin pa_w = b10_r; pb_w = b01_r; end
      5'd15: begin pa_w = b11_r; pb_w = b11_r; end
      5'd16: begin pa_w = r00_r; pb_w = remb_r; end
      5'd17: begin pa_w = r01_r; pb_w = two_w; end
      default: ;
    endcase
  end

  // even selects open a sum, odd selects add into it
  assign tk_w  = cmd.prod_sel[2:1];
  assign sum_w = cmd.prod_sel[0] ? madd(t_r[tk_w], acc_r, m_r) : acc_r;

  always_comb begin
    fin_w = (n_r == '0) ? two_w : t_r[0];
    if (em1_r && !n_r[0]) fin_w = (fin_w == '0) ? m_r - VALUE_BITS'(1) : fin_w - VALUE_BITS'(1);
    if (m_r == '0) fin_w = '0;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lsmp_pkg::OP_LOAD: begin
        m_r    <= modulus;
        em1_r  <= even_minus_one;
        n_r    <= term_index;
        e_r    <= term_index - INDEX_BITS'(1);
        neg_r  <= neg_w;
        numc_r <= num_w;
        numb_r <= {33'd0, base_term};
        remc_r <= '0;
        remb_r <= '0;
        rcnt_r <= '0;
      end
      lsmp_pkg::OP_RED_STEP: begin
        // reduce coefficient and base side by side, one bit a cycle
        remc_r <= rstep(remc_r, numc_r[RW-1], m_r);
        remb_r <= rstep(remb_r, numb_r[RW-1], m_r);
        numc_r <= numc_r << 1;
        numb_r <= numb_r << 1;
        rcnt_r <= rcnt_r + CW'(1);
      end
      lsmp_pkg::OP_SETUP: begin
        b00_r <= remb_r; b01_r <= c_w; b10_r <= one_w; b11_r <= '0;
        r00_r <= one_w; r01_r <= '0; r10_r <= '0; r11_r <= one_w;
      end
      lsmp_pkg::OP_MUL_START: begin
        ma_r  <= pa_w;
        mb_r  <= pb_w;
        acc_r <= '0;
      end
      lsmp_pkg::OP_MUL_STEP: begin
        if (mb_r[0]) acc_r <= madd(acc_r, ma_r, m_r);
        ma_r <= madd(ma_r, ma_r, m_r);
        mb_r <= mb_r >> 1;
      end
      lsmp_pkg::OP_MUL_WB: begin
        t_r[tk_w] <= sum_w;
        if (cmd.prod_sel == lsmp_pkg::SEL_MUL_LAST) begin
          r00_r <= t_r[0]; r01_r <= t_r[1]; r10_r <= t_r[2]; r11_r <= sum_w;
        end
        if (cmd.prod_sel == lsmp_pkg::SEL_SQR_LAST) begin
          b00_r <= t_r[0]; b01_r <= t_r[1]; b10_r <= t_r[2]; b11_r <= sum_w;
          e_r   <= e_r >> 1;
        end
      end
      lsmp_pkg::OP_FINAL: begin
        result_r <= fin_w;
      end
      default: ;
    endcase
  end

  assign result = result_r;

  assign status.red_last = (rcnt_r == CW'(RW - 1));
  assign status.mul_done = (mb_r == '0);
  assign status.exp_zero = (e_r == '0);
  assign status.exp_bit  = e_r[0];
  assign status.skip_pow = (m_r == '0) || (n_r == '0);

endmodule
`default_nettype wire
